// ===== hdl/rgb2hsv_pkg.sv =====
// Shared constants, types and the divider step function for the RGB to HSV converter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rgb2hsv_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int FRACTION_BITS = 16;

   // six times the largest channel difference fits in three more bits
   localparam int DIV_WIDTH  = CHANNEL_BITS + 3;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = (FRACTION_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int QUO_BITS   = DIV_STAGES * DIV_STEPS;

   localparam logic [FRACTION_BITS:0] SAT_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef struct packed {
      logic [DIV_WIDTH-1:0]    hue_rem;
      logic [DIV_WIDTH-1:0]    hue_div;
      logic [QUO_BITS-1:0]     hue_quo;
      logic [DIV_WIDTH-1:0]    sat_rem;
      logic [DIV_WIDTH-1:0]    sat_div;
      logic [QUO_BITS-1:0]     sat_quo;
      logic                    sat_int;
      logic [CHANNEL_BITS-1:0] brightness;
      logic                    achromatic;
   } div_word_type;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [DIV_WIDTH:0] div_step(input logic [DIV_WIDTH-1:0] rem,
                                                   input logic [DIV_WIDTH-1:0] div);
      logic [DIV_WIDTH:0] shifted;
      logic [DIV_WIDTH:0] diff;
      shifted = {rem, 1'b0};
      diff    = shifted - {1'b0, div};
      if (shifted >= {1'b0, div}) begin
         div_step = {1'b1, diff[DIV_WIDTH-1:0]};
      end else begin
         div_step = {1'b0, shifted[DIV_WIDTH-1:0]};
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb2hsv_channels.sv =====
// Handshake interfaces for the pixel words in and the HSV words out.
// Depends on rgb2hsv_pkg for the field widths.
`default_nettype none

interface rgb2hsv_pixel_if import rgb2hsv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb2hsv_color_if import rgb2hsv_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS-1:0] hue;
   logic [FRACTION_BITS:0]   saturation;
   logic [CHANNEL_BITS-1:0]  brightness;
   logic                     achromatic;

   modport source (output valid, output hue, output saturation, output brightness,
                   output achromatic, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input achromatic, output ready);
endinterface

`default_nettype wire

// ===== hdl/rgb2hsv_div_stage.sv =====
// One stage of the pipelined hue and saturation dividers: DIV_STEPS restoring steps on each word it takes.
// Depends on rgb2hsv_pkg for the word type and the step function.
`default_nettype none

module rgb2hsv_div_stage import rgb2hsv_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         up_valid,
   input  wire div_word_type up_word,
   output logic              take,
   input  wire logic         down_take,
   output logic              down_valid,
   output div_word_type      down_word
);

   logic         valid_ff;
   logic         valid_in;
   div_word_type word_ff;
   div_word_type word_in;
   logic [DIV_WIDTH:0] hue_step;
   logic [DIV_WIDTH:0] sat_step;

   assign take     = !valid_ff || down_take;
   assign valid_in = take ? up_valid : valid_ff;

   always_comb begin
      word_in  = up_word;
      hue_step = '0;
      sat_step = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         hue_step        = div_step(word_in.hue_rem, word_in.hue_div);
         sat_step        = div_step(word_in.sat_rem, word_in.sat_div);
         word_in.hue_rem = hue_step[DIV_WIDTH-1:0];
         word_in.sat_rem = sat_step[DIV_WIDTH-1:0];
         word_in.hue_quo = {word_in.hue_quo[QUO_BITS-2:0], hue_step[DIV_WIDTH]};
         word_in.sat_quo = {word_in.sat_quo[QUO_BITS-2:0], sat_step[DIV_WIDTH]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule

`default_nettype wire

// ===== hdl/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter: sector logic, divider pipeline and output register.
// Depends on rgb2hsv_pkg, the channel interfaces and rgb2hsv_div_stage.
`default_nettype none

// Converts one RGB pixel per clock, unless back-pressure stalls the pipeline, into hue and
// saturation as fractions of 2^FRACTION_BITS, brightness as the largest channel, and a flag
// for gray pixels (hue and saturation then 0). A word passes front stage one (max, min and
// sector), front stage two (divider operands), DIV_STAGES divider stages of DIV_STEPS
// quotient bits each, and the output register. A new pixel is taken every clock unless
// stalled; a stage holds its word only if the next is full and stalled, so bubbles close up.
module rgb_to_hsv_converter import rgb2hsv_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   rgb2hsv_pixel_if.sink  req,
   rgb2hsv_color_if.source rsp
);

   // front stage one: max, min, sector, channel difference
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic                      s1_take;
   logic [CHANNEL_BITS-1:0]   s1_max_ff;
   logic [CHANNEL_BITS-1:0]   s1_max_in;
   logic [CHANNEL_BITS-1:0]   s1_min_ff;
   logic [CHANNEL_BITS-1:0]   s1_min_in;
   logic [1:0]                s1_sector_ff;
   logic [1:0]                s1_sector_in;
   logic signed [CHANNEL_BITS:0] s1_diff_ff;
   logic signed [CHANNEL_BITS:0] s1_diff_in;

   // front stage two: divider operands
   logic                      s2_valid_ff;
   logic                      s2_valid_in;
   logic                      s2_take;
   div_word_type              s2_word_ff;
   div_word_type              s2_word_in;
   logic [CHANNEL_BITS-1:0]   s2_delta;
   logic [DIV_WIDTH-1:0]      s2_delta_ext;
   logic [DIV_WIDTH-1:0]      s2_six_delta;
   logic [DIV_WIDTH-1:0]      s2_offset;
   logic signed [DIV_WIDTH:0] s2_sum;
   logic signed [DIV_WIDTH:0] s2_wrapped;

   // divider pipeline
   logic                      div_valid [DIV_STAGES];
   div_word_type              div_word  [DIV_STAGES];
   logic                      div_take  [DIV_STAGES];

   // output register
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      out_take;
   logic [FRACTION_BITS-1:0]  out_hue_ff;
   logic [FRACTION_BITS-1:0]  out_hue_in;
   logic [FRACTION_BITS:0]    out_sat_ff;
   logic [FRACTION_BITS:0]    out_sat_in;
   logic [CHANNEL_BITS-1:0]   out_bright_ff;
   logic                      out_gray_ff;
   div_word_type              last_word;

   // stage one
   assign s1_take     = !s1_valid_ff || s2_take;
   assign s1_valid_in = s1_take ? req.valid : s1_valid_ff;
   assign req.ready   = s1_take;

   always_comb begin
      if (req.red >= req.green && req.red >= req.blue) begin
         s1_sector_in = SECTOR_RED;
         s1_max_in    = req.red;
         s1_diff_in   = $signed({1'b0, req.green}) - $signed({1'b0, req.blue});
      end else if (req.green >= req.blue) begin
         s1_sector_in = SECTOR_GREEN;
         s1_max_in    = req.green;
         s1_diff_in   = $signed({1'b0, req.blue}) - $signed({1'b0, req.red});
      end else begin
         s1_sector_in = SECTOR_BLUE;
         s1_max_in    = req.blue;
         s1_diff_in   = $signed({1'b0, req.red}) - $signed({1'b0, req.green});
      end
      if (req.red <= req.green && req.red <= req.blue) begin
         s1_min_in = req.red;
      end else if (req.green <= req.blue) begin
         s1_min_in = req.green;
      end else begin
         s1_min_in = req.blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_max_ff    <= s1_max_in;
         s1_min_ff    <= s1_min_in;
         s1_sector_ff <= s1_sector_in;
         s1_diff_ff   <= s1_diff_in;
      end
   end

   // stage two
   assign s2_take     = !s2_valid_ff || div_take[0];
   assign s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      s2_delta     = s1_max_ff - s1_min_ff;
      s2_delta_ext = {3'b000, s2_delta};
      s2_six_delta = (s2_delta_ext << 2) + (s2_delta_ext << 1);
      case (s1_sector_ff)
         SECTOR_RED:   s2_offset = '0;
         SECTOR_GREEN: s2_offset = s2_delta_ext << 1;
         SECTOR_BLUE:  s2_offset = s2_delta_ext << 2;
         default:      s2_offset = '0;
      endcase
      s2_sum = $signed({1'b0, s2_offset})
             + $signed({{(DIV_WIDTH - CHANNEL_BITS){s1_diff_ff[CHANNEL_BITS]}}, s1_diff_ff});
      if (s2_sum < 0) begin
         s2_wrapped = s2_sum + $signed({1'b0, s2_six_delta});
      end else begin
         s2_wrapped = s2_sum;
      end
      s2_word_in.hue_rem    = s2_wrapped[DIV_WIDTH-1:0];
      s2_word_in.hue_div    = s2_six_delta;
      s2_word_in.hue_quo    = '0;
      s2_word_in.sat_int    = (s2_delta == s1_max_ff);
      s2_word_in.sat_rem    = s2_word_in.sat_int ? '0 : s2_delta_ext;
      s2_word_in.sat_div    = {3'b000, s1_max_ff};
      s2_word_in.sat_quo    = '0;
      s2_word_in.brightness = s1_max_ff;
      s2_word_in.achromatic = (s2_delta == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take) begin
         s2_word_ff <= s2_word_in;
      end
   end

   // divider stages
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      if (k == 0) begin : g_first
         rgb2hsv_div_stage u_stage (
            .clock      (clock),
            .reset      (reset),
            .up_valid   (s2_valid_ff),
            .up_word    (s2_word_ff),
            .take       (div_take[k]),
            .down_take  ((k == DIV_STAGES - 1) ? out_take : div_take[(k + 1) % DIV_STAGES]),
            .down_valid (div_valid[k]),
            .down_word  (div_word[k])
         );
      end else begin : g_next
         rgb2hsv_div_stage u_stage (
            .clock      (clock),
            .reset      (reset),
            .up_valid   (div_valid[k-1]),
            .up_word    (div_word[k-1]),
            .take       (div_take[k]),
            .down_take  ((k == DIV_STAGES - 1) ? out_take : div_take[(k + 1) % DIV_STAGES]),
            .down_valid (div_valid[k]),
            .down_word  (div_word[k])
         );
      end
   end

   // output register
   assign last_word    = div_word[DIV_STAGES-1];
   assign out_take     = !out_valid_ff || rsp.ready;
   assign out_valid_in = out_take ? div_valid[DIV_STAGES-1] : out_valid_ff;

   always_comb begin
      if (last_word.achromatic) begin
         out_hue_in = '0;
         out_sat_in = '0;
      end else begin
         out_hue_in = last_word.hue_quo[QUO_BITS-1 -: FRACTION_BITS];
         out_sat_in = {last_word.sat_int, last_word.sat_quo[QUO_BITS-1 -: FRACTION_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_hue_ff    <= out_hue_in;
         out_sat_ff    <= out_sat_in;
         out_bright_ff <= last_word.brightness;
         out_gray_ff   <= last_word.achromatic;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.hue        = out_hue_ff;
   assign rsp.saturation = out_sat_ff;
   assign rsp.brightness = out_bright_ff;
   assign rsp.achromatic = out_gray_ff;

`ifndef SYNTH
   a_accept_fills_front: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> s1_valid_ff)
      else $error("accepted pixel word did not enter the front stage");

   a_gray_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.achromatic) |-> (rsp.hue == '0 && rsp.saturation == '0))
      else $error("gray word with nonzero hue or saturation");

   a_color_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.achromatic) |-> (rsp.saturation != '0 && rsp.brightness != '0))
      else $error("colored word with zero saturation or brightness");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.saturation <= SAT_ONE))
      else $error("saturation above one");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_rgb_to_hsv_converter.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rgb_to_hsv_converter: drives pixel words, predicts HSV words.
// Depends on rgb2hsv_pkg, the rgb2hsv channel interfaces and the converter RTL.

module tb_rgb_to_hsv_converter;
   import rgb2hsv_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PIXELS  = 690;
   localparam int DRAIN_CYCLES   = 24;

   typedef logic [CHANNEL_BITS-1:0] chan_type;

   typedef struct packed {
      logic [FRACTION_BITS-1:0] hue;
      logic [FRACTION_BITS:0]   saturation;
      logic [CHANNEL_BITS-1:0]  brightness;
      logic                     achromatic;
   } hsv_word_type;

   class hsv_scoreboard;
      hsv_word_type pending_hsv[$];
      int           mismatches;
      int           pixels_taken;
      int           gray_pixels;
      int           words_checked;

      function hsv_word_type predict_hsv(chan_type r, chan_type g, chan_type b);
         hsv_word_type w;
         longint       rr, gg, bb, mx, mn, d, t;
         longint       sat_l, hue_l;
         rr = r;
         gg = g;
         bb = b;
         mx = rr;
         mn = rr;
         if (gg > mx) mx = gg;
         if (bb > mx) mx = bb;
         if (gg < mn) mn = gg;
         if (bb < mn) mn = bb;
         d = mx - mn;
         w.brightness = mx[CHANNEL_BITS-1:0];
         w.achromatic = (d == 0);
         sat_l = 0;
         if (mx != 0) sat_l = (d << FRACTION_BITS) / mx;
         w.saturation = sat_l[FRACTION_BITS:0];
         hue_l = 0;
         if (d != 0) begin
            if (rr == mx) t = gg - bb;
            else if (gg == mx) t = 2 * d + (bb - rr);
            else t = 4 * d + (rr - gg);
            if (t < 0) t = t + 6 * d;
            hue_l = (t << FRACTION_BITS) / (6 * d);
         end
         w.hue = hue_l[FRACTION_BITS-1:0];
         return w;
      endfunction

      function void note_pixel(chan_type r, chan_type g, chan_type b);
         hsv_word_type w;
         w = predict_hsv(r, g, b);
         pixels_taken++;
         if (w.achromatic) gray_pixels++;
         pending_hsv.push_back(w);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_color(hsv_word_type got);
         hsv_word_type exp_w;
         if (pending_hsv.size() == 0) begin
            report_mismatch($sformatf("HSV word %h with no pixel pending", got));
         end else begin
            exp_w = pending_hsv.pop_front();
            words_checked++;
            if (got.hue !== exp_w.hue)
               report_mismatch($sformatf("hue %0d, want %0d", got.hue, exp_w.hue));
            if (got.saturation !== exp_w.saturation)
               report_mismatch($sformatf("saturation %0d, want %0d",
                                         got.saturation, exp_w.saturation));
            if (got.brightness !== exp_w.brightness)
               report_mismatch($sformatf("brightness %0d, want %0d",
                                         got.brightness, exp_w.brightness));
            if (got.achromatic !== exp_w.achromatic)
               report_mismatch($sformatf("achromatic %b, want %b",
                                         got.achromatic, exp_w.achromatic));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   idle_cycles;

   hsv_scoreboard sb = new();

   rgb2hsv_pixel_if pix ();
   rgb2hsv_color_if col ();

   rgb_to_hsv_converter dut (
      .clock (clock),
      .reset (reset),
      .req   (pix),
      .rsp   (col)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) begin
      col.ready <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((pix.valid && pix.ready) || (col.valid && col.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (pix.valid && pix.ready) sb.note_pixel(pix.red, pix.green, pix.blue);
         if (col.valid && col.ready)
            sb.check_color({col.hue, col.saturation, col.brightness, col.achromatic});
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task send_pixel(input chan_type r, input chan_type g, input chan_type b);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         pix.valid <= 1'b0;
      end
      @(negedge clock);
      pix.valid <= 1'b1;
      pix.red   <= r;
      pix.green <= g;
      pix.blue  <= b;
      do @(posedge clock); while (!pix.ready);
   endtask

   task send_random_pixel();
      chan_type r, g, b, lo, hi;
      int       kind;
      kind = $urandom_range(9);
      r = chan_type'($urandom);
      g = chan_type'($urandom);
      b = chan_type'($urandom);
      case (kind)
         0: begin
            g = r;
            b = r;
         end
         1: begin
            hi = chan_type'($urandom_range(255, 1));
            lo = chan_type'($urandom_range(hi - 1, 0));
            case ($urandom_range(2))
               0: send_pixel(hi, hi, lo);
               1: send_pixel(lo, hi, hi);
               default: send_pixel(hi, lo, hi);
            endcase
            return;
         end
         2: begin
            g = (r > 251) ? chan_type'(r - $urandom_range(3))
                          : chan_type'(r + $urandom_range(3));
            b = (r > 251) ? chan_type'(r - $urandom_range(3))
                          : chan_type'(r + $urandom_range(3));
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   initial begin
      reset       = 1'b1;
      tx_idle_pct = 9;
      rx_idle_pct = 72;
      pix.valid   = 1'b0;
      pix.red     = '0;
      pix.green   = '0;
      pix.blue    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd1);
      send_pixel(8'd1, 8'd255, 8'd0);
      send_pixel(8'd1, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd1, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd1, 8'd1, 8'd0);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd170, 8'd85, 8'd255);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 9;
               rx_idle_pct = 72;
            end
            1: begin
               tx_idle_pct = 72;
               rx_idle_pct = 9;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         repeat (RANDOM_PIXELS / 3) send_random_pixel();
      end

      @(negedge clock);
      pix.valid <= 1'b0;
      while (sb.pending_hsv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d pixels (%0d gray) and checked %0d HSV words,",
               sb.pixels_taken, sb.gray_pixels, sb.words_checked);
      $display("under sender-heavy, receiver-heavy and back-to-back handshake idling.");
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/rgb2hsv_pkg.sv
hdl/rgb2hsv_channels.sv
hdl/rgb2hsv_div_stage.sv
hdl/rgb_to_hsv_converter.sv
dv/tb_rgb_to_hsv_converter.sv
